@@ hw/rtl/lped_pkg.sv @@
// Shared types and constants for the LED pulse envelope driver.
package lped_pkg;

  // Input operation codes
  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_VOICE = 2'd1,
    OP_BEAT  = 2'd2,
    OP_MUTE  = 2'd3
  } op_t;

  // LED mode codes
  typedef enum logic [1:0] {
    MODE_OFF  = 2'd0,
    MODE_STEP = 2'd1,
    MODE_MUTE = 2'd2,
    MODE_BEAT = 2'd3
  } mode_t;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_LED_MODE     = 3'd0,
    REG_SOURCE_VOICE = 3'd1,
    REG_COLOR_RED    = 3'd2,
    REG_COLOR_GREEN  = 3'd3,
    REG_COLOR_BLUE   = 3'd4,
    REG_BRIGHTNESS   = 3'd5,
    REG_FLASH_MS     = 3'd6,
    REG_UNUSED       = 3'd7
  } reg_idx_t;

  // Command kinds passed from the front end to the back end
  typedef enum logic [1:0] {
    CMD_TICK = 2'd0,
    CMD_POST = 2'd1,
    CMD_MUTE = 2'd2
  } cmd_kind_t;

  localparam logic [9:0]  PEAK_CAP      = 10'd220;
  localparam logic [16:0] DUR_MIN       = 17'd40;
  localparam logic [16:0] DUR_MAX       = 17'd180;
  localparam logic [3:0]  RENDER_PERIOD = 4'd10;
  localparam logic [9:0]  REST_PERIOD   = 10'd500;
  localparam logic [8:0]  BOOST_KICK    = 9'd20;
  localparam logic [8:0]  BOOST_SNARE   = 9'd10;
  localparam logic [8:0]  BOOST_CLAP    = 9'd8;
  localparam logic [8:0]  BOOST_BEAT    = 9'd12;
  localparam logic [3:0]  VOICE_KICK    = 4'd0;
  localparam logic [3:0]  VOICE_SNARE   = 4'd1;
  localparam logic [3:0]  VOICE_CLAP    = 4'd2;
  // resting level is brightness / 4
  localparam int unsigned REST_SHIFT    = 2;
  localparam int unsigned DIV_STEPS     = 8;

  // Configuration register set
  typedef struct packed {
    mode_t       led_mode;
    logic [3:0]  source_voice;
    logic [7:0]  color_red;
    logic [7:0]  color_green;
    logic [7:0]  color_blue;
    logic [7:0]  base_brightness;
    logic [15:0] flash_ms;
  } cfg_t;

  // Classified command held in the queue
  typedef struct packed {
    cmd_kind_t  kind;
    logic [7:0] peak;
    logic [7:0] duration;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] bright;
    logic       unmuted;
  } cmd_t;

endpackage

@@ hw/rtl/lped_if.sv @@
// Request channel interfaces for the LED pulse envelope driver.
interface lped_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] op;
  logic [3:0] voice;
  logic       muted;

  modport source (output valid, output op, output voice, output muted, input ready);
  modport sink   (input valid, input op, input voice, input muted, output ready);
endinterface

interface lped_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

@@ hw/rtl/lped_front.sv @@
// Front end: classifies incoming requests and precomputes pulse parameters.
module lped_front (
  input  lped_pkg::cfg_t  cfg,
  input  logic            req_valid,
  input  logic [1:0]      req_op,
  input  logic [3:0]      req_voice,
  input  logic            req_muted,
  input  logic            q_full,
  output logic            req_ready,
  output logic            q_push,
  output lped_pkg::cmd_t  q_data
);

  logic       keep;
  logic [8:0] boost;
  logic [8:0] boosted;
  logic [9:0] peak_raw;
  logic [16:0] dur_raw;
  logic [7:0] peak;
  logic [7:0] dur;
  lped_pkg::cmd_kind_t kind;

  assign req_ready = !q_full;

  // Decide whether the request matters in the current mode
  always_comb begin
    keep  = 1'b0;
    kind  = lped_pkg::CMD_TICK;
    boost = '0;
    unique case (lped_pkg::op_t'(req_op))
      lped_pkg::OP_TICK: begin
        keep = 1'b1;
      end
      lped_pkg::OP_VOICE: begin
        keep = (cfg.led_mode == lped_pkg::MODE_STEP) && (req_voice == cfg.source_voice);
        kind = lped_pkg::CMD_POST;
        priority if (req_voice == lped_pkg::VOICE_KICK)  boost = lped_pkg::BOOST_KICK;
        else if (req_voice == lped_pkg::VOICE_SNARE)     boost = lped_pkg::BOOST_SNARE;
        else if (req_voice == lped_pkg::VOICE_CLAP)      boost = lped_pkg::BOOST_CLAP;
        else                                             boost = '0;
      end
      lped_pkg::OP_BEAT: begin
        keep  = (cfg.led_mode == lped_pkg::MODE_BEAT);
        kind  = lped_pkg::CMD_POST;
        boost = lped_pkg::BOOST_BEAT;
      end
      lped_pkg::OP_MUTE: begin
        keep = (cfg.led_mode == lped_pkg::MODE_MUTE);
        kind = lped_pkg::CMD_MUTE;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  // Peak = min(2*(brightness+boost), cap); duration = clamp(2*flash_ms)
  always_comb begin
    boosted  = {1'b0, cfg.base_brightness} + boost;
    peak_raw = {boosted, 1'b0};
    peak     = (peak_raw > lped_pkg::PEAK_CAP) ? lped_pkg::PEAK_CAP[7:0] : peak_raw[7:0];
    dur_raw  = {cfg.flash_ms, 1'b0};
    priority if (dur_raw < lped_pkg::DUR_MIN) dur = lped_pkg::DUR_MIN[7:0];
    else if (dur_raw > lped_pkg::DUR_MAX)     dur = lped_pkg::DUR_MAX[7:0];
    else                                      dur = dur_raw[7:0];
  end

  assign q_push          = req_valid && req_ready && keep;
  assign q_data.kind     = kind;
  assign q_data.peak     = peak;
  assign q_data.duration = dur;
  assign q_data.red      = cfg.color_red;
  assign q_data.green    = cfg.color_green;
  assign q_data.blue     = cfg.color_blue;
  assign q_data.bright   = cfg.base_brightness;
  assign q_data.unmuted  = !req_muted;

endmodule

@@ hw/rtl/lped_fifo.sv @@
// Short command queue between the front end and the back end.
module lped_fifo #(
  parameter int unsigned DEPTH = 4
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  lped_pkg::cmd_t wr_data,
  input  logic           pop,
  output logic           full,
  output logic           valid,
  output lped_pkg::cmd_t rd_data
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  lped_pkg::cmd_t mem [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;

  assign full    = (count_r == FULL_CNT);
  assign valid   = (count_r != '0);
  assign rd_data = mem[rd_ptr_r];

  // Pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) wr_ptr_nxt = (wr_ptr_r == LAST) ? '0 : wr_ptr_r + 1'b1;
    if (pop)  rd_ptr_nxt = (rd_ptr_r == LAST) ? '0 : rd_ptr_r + 1'b1;
    if (push && !pop)      count_nxt = count_r + 1'b1;
    else if (pop && !push) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr_r] <= wr_data;
  end

endmodule

@@ hw/rtl/lped_back.sv @@
// Back end: pulse mailbox, envelope timing, serial divide and LED output register.
module lped_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_valid,
  input  lped_pkg::cmd_t q_data,
  output logic           q_pop,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [7:0]     out_red,
  output logic [7:0]     out_green,
  output logic [7:0]     out_blue
);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_MUL1  = 5'b00010,
    ST_MUL2  = 5'b00100,
    ST_DIV   = 5'b01000,
    ST_DRIVE = 5'b10000
  } back_st_t;

  back_st_t    st_r, st_nxt;

  // mailbox
  logic        pending_valid_r, pending_valid_nxt;
  logic [7:0]  pending_peak_r, pending_peak_nxt;
  logic [7:0]  pending_dur_r, pending_dur_nxt;
  logic [7:0]  pend_red_r, pend_red_nxt;
  logic [7:0]  pend_green_r, pend_green_nxt;
  logic [7:0]  pend_blue_r, pend_blue_nxt;
  // running pulse
  logic        pulsing_r, pulsing_nxt;
  logic [7:0]  pulse_peak_r, pulse_peak_nxt;
  logic [7:0]  pulse_dur_r, pulse_dur_nxt;
  logic [7:0]  pulse_elapsed_r, pulse_elapsed_nxt;
  logic [7:0]  pul_red_r, pul_red_nxt;
  logic [7:0]  pul_green_r, pul_green_nxt;
  logic [7:0]  pul_blue_r, pul_blue_nxt;
  // timers and resting state
  logic [3:0]  since_render_r, since_render_nxt;
  logic [9:0]  since_update_r, since_update_nxt;
  logic        unmuted_lit_r, unmuted_lit_nxt;
  logic        resting_dirty_r, resting_dirty_nxt;
  logic [7:0]  rest_red_r, rest_red_nxt;
  logic [7:0]  rest_green_r, rest_green_nxt;
  logic [7:0]  rest_blue_r, rest_blue_nxt;
  logic [7:0]  rest_bright_r, rest_bright_nxt;
  // render datapath
  logic [7:0]  col_red_r, col_red_nxt;
  logic [7:0]  col_green_r, col_green_nxt;
  logic [7:0]  col_blue_r, col_blue_nxt;
  logic [7:0]  bright_r, bright_nxt;
  logic [7:0]  remain_r, remain_nxt;
  logic [15:0] prod_r, prod_nxt;
  logic [15:0] den_r, den_nxt;
  logic [23:0] num_r, num_nxt;
  logic [23:0] dsh_r, dsh_nxt;
  logic [7:0]  quot_r, quot_nxt;
  logic [2:0]  div_cnt_r, div_cnt_nxt;
  // output register
  logic        out_valid_r, out_valid_nxt;
  logic [7:0]  out_red_r, out_red_nxt;
  logic [7:0]  out_green_r, out_green_nxt;
  logic [7:0]  out_blue_r, out_blue_nxt;

  logic [15:0] mul_red, mul_green, mul_blue;
  logic        out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign q_pop     = (st_r == ST_IDLE) && q_valid;
  assign out_valid = out_valid_r;
  assign out_red   = out_red_r;
  assign out_green = out_green_r;
  assign out_blue  = out_blue_r;

  // channel scaling: (colour * brightness) >> 8
  assign mul_red   = {8'd0, col_red_r} * {8'd0, bright_r};
  assign mul_green = {8'd0, col_green_r} * {8'd0, bright_r};
  assign mul_blue  = {8'd0, col_blue_r} * {8'd0, bright_r};

  // Command execution and sequencing
  always_comb begin
    logic [9:0] su;
    logic [3:0] sr;
    logic [7:0] pe;
    logic [7:0] pk;
    logic [7:0] du;
    logic [7:0] cr, cg, cb;
    logic       pul;
    logic       done;
    logic       dirty;
    logic       take;

    st_nxt            = st_r;
    pending_valid_nxt = pending_valid_r;
    pending_peak_nxt  = pending_peak_r;
    pending_dur_nxt   = pending_dur_r;
    pend_red_nxt      = pend_red_r;
    pend_green_nxt    = pend_green_r;
    pend_blue_nxt     = pend_blue_r;
    pulsing_nxt       = pulsing_r;
    pulse_peak_nxt    = pulse_peak_r;
    pulse_dur_nxt     = pulse_dur_r;
    pulse_elapsed_nxt = pulse_elapsed_r;
    pul_red_nxt       = pul_red_r;
    pul_green_nxt     = pul_green_r;
    pul_blue_nxt      = pul_blue_r;
    since_render_nxt  = since_render_r;
    since_update_nxt  = since_update_r;
    unmuted_lit_nxt   = unmuted_lit_r;
    resting_dirty_nxt = resting_dirty_r;
    rest_red_nxt      = rest_red_r;
    rest_green_nxt    = rest_green_r;
    rest_blue_nxt     = rest_blue_r;
    rest_bright_nxt   = rest_bright_r;
    col_red_nxt       = col_red_r;
    col_green_nxt     = col_green_r;
    col_blue_nxt      = col_blue_r;
    bright_nxt        = bright_r;
    remain_nxt        = remain_r;
    prod_nxt          = prod_r;
    den_nxt           = den_r;
    num_nxt           = num_r;
    dsh_nxt           = dsh_r;
    quot_nxt          = quot_r;
    div_cnt_nxt       = div_cnt_r;
    out_valid_nxt     = out_valid_r && !out_ready;
    out_red_nxt       = out_red_r;
    out_green_nxt     = out_green_r;
    out_blue_nxt      = out_blue_r;

    su    = since_update_r;
    sr    = since_render_r;
    pe    = pulse_elapsed_r;
    pk    = pulse_peak_r;
    du    = pulse_dur_r;
    cr    = pul_red_r;
    cg    = pul_green_r;
    cb    = pul_blue_r;
    pul   = pulsing_r;
    done  = 1'b0;
    dirty = resting_dirty_r;
    take  = 1'b0;

    unique case (st_r)
      ST_IDLE: begin
        if (q_valid) begin
          unique case (q_data.kind)
            lped_pkg::CMD_POST: begin
              // single-slot mailbox: a post to a full slot is dropped
              if (!pending_valid_r) begin
                pending_valid_nxt = 1'b1;
                pending_peak_nxt  = q_data.peak;
                pending_dur_nxt   = q_data.duration;
                pend_red_nxt      = q_data.red;
                pend_green_nxt    = q_data.green;
                pend_blue_nxt     = q_data.blue;
              end
            end
            lped_pkg::CMD_MUTE: begin
              unmuted_lit_nxt   = q_data.unmuted;
              rest_red_nxt      = q_data.red;
              rest_green_nxt    = q_data.green;
              rest_blue_nxt     = q_data.blue;
              rest_bright_nxt   = q_data.bright;
              resting_dirty_nxt = 1'b1;
            end
            lped_pkg::CMD_TICK: begin
              // advance timers
              if (su <= lped_pkg::REST_PERIOD) su = su + 10'd1;
              if (sr < lped_pkg::RENDER_PERIOD) sr = sr + 4'd1;
              if (pul && pe != 8'hFF) pe = pe + 8'd1;

              // start a pending pulse
              if (pending_valid_r) begin
                pending_valid_nxt = 1'b0;
                pk  = pending_peak_r;
                du  = pending_dur_r;
                cr  = pend_red_r;
                cg  = pend_green_r;
                cb  = pend_blue_r;
                pe  = '0;
                sr  = '0;
                pul = (pk != '0) && (du != '0);
                if (pul) begin
                  col_red_nxt   = cr;
                  col_green_nxt = cg;
                  col_blue_nxt  = cb;
                  bright_nxt    = pk;
                  take          = 1'b1;
                  done          = 1'b1;
                end
              end

              if (!done) begin
                if (pul) begin
                  if (pe >= du) begin
                    // end of pulse: LED off
                    pul           = 1'b0;
                    su            = '0;
                    col_red_nxt   = '0;
                    col_green_nxt = '0;
                    col_blue_nxt  = '0;
                    bright_nxt    = '0;
                    take          = 1'b1;
                  end else if (sr >= lped_pkg::RENDER_PERIOD) begin
                    // envelope re-render through the multiply/divide path
                    sr            = '0;
                    remain_nxt    = du - pe;
                    col_red_nxt   = cr;
                    col_green_nxt = cg;
                    col_blue_nxt  = cb;
                    st_nxt        = ST_MUL1;
                  end
                end else if (dirty || su > lped_pkg::REST_PERIOD) begin
                  // resting colour
                  dirty = 1'b0;
                  su    = '0;
                  if (unmuted_lit_r) begin
                    col_red_nxt   = rest_red_r;
                    col_green_nxt = rest_green_r;
                    col_blue_nxt  = rest_blue_r;
                    bright_nxt    = rest_bright_r >> lped_pkg::REST_SHIFT;
                  end else begin
                    col_red_nxt   = '0;
                    col_green_nxt = '0;
                    col_blue_nxt  = '0;
                    bright_nxt    = '0;
                  end
                  take = 1'b1;
                end
              end

              since_update_nxt  = su;
              since_render_nxt  = sr;
              pulse_elapsed_nxt = pe;
              pulse_peak_nxt    = pk;
              pulse_dur_nxt     = du;
              pul_red_nxt       = cr;
              pul_green_nxt     = cg;
              pul_blue_nxt      = cb;
              pulsing_nxt       = pul;
              resting_dirty_nxt = dirty;
              if (take) st_nxt = ST_DRIVE;
            end
            default: begin
            end
          endcase
        end
      end
      ST_MUL1: begin
        prod_nxt = {8'd0, pulse_peak_r} * {8'd0, remain_r};
        den_nxt  = {8'd0, pulse_dur_r} * {8'd0, pulse_dur_r};
        st_nxt   = ST_MUL2;
      end
      ST_MUL2: begin
        num_nxt     = {8'd0, prod_r} * {16'd0, remain_r};
        dsh_nxt     = {1'b0, den_r, 7'd0};
        quot_nxt    = '0;
        div_cnt_nxt = 3'(lped_pkg::DIV_STEPS - 1);
        st_nxt      = ST_DIV;
      end
      ST_DIV: begin
        // restoring divide, one quotient bit per cycle
        if (num_r >= dsh_r) begin
          num_nxt  = num_r - dsh_r;
          quot_nxt = {quot_r[6:0], 1'b1};
        end else begin
          quot_nxt = {quot_r[6:0], 1'b0};
        end
        dsh_nxt     = dsh_r >> 1;
        div_cnt_nxt = div_cnt_r - 3'd1;
        if (div_cnt_r == '0) begin
          bright_nxt = quot_nxt;
          st_nxt     = ST_DRIVE;
        end
      end
      ST_DRIVE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_red_nxt   = mul_red[15:8];
          out_green_nxt = mul_green[15:8];
          out_blue_nxt  = mul_blue[15:8];
          st_nxt        = ST_IDLE;
        end
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r            <= ST_IDLE;
      pending_valid_r <= 1'b0;
      pending_peak_r  <= '0;
      pending_dur_r   <= '0;
      pend_red_r      <= '0;
      pend_green_r    <= '0;
      pend_blue_r     <= '0;
      pulsing_r       <= 1'b0;
      pulse_peak_r    <= '0;
      pulse_dur_r     <= '0;
      pulse_elapsed_r <= '0;
      pul_red_r       <= '0;
      pul_green_r     <= '0;
      pul_blue_r      <= '0;
      since_render_r  <= '0;
      since_update_r  <= '0;
      unmuted_lit_r   <= 1'b0;
      resting_dirty_r <= 1'b0;
      rest_red_r      <= '0;
      rest_green_r    <= '0;
      rest_blue_r     <= '0;
      rest_bright_r   <= '0;
      out_valid_r     <= 1'b0;
    end else begin
      st_r            <= st_nxt;
      pending_valid_r <= pending_valid_nxt;
      pending_peak_r  <= pending_peak_nxt;
      pending_dur_r   <= pending_dur_nxt;
      pend_red_r      <= pend_red_nxt;
      pend_green_r    <= pend_green_nxt;
      pend_blue_r     <= pend_blue_nxt;
      pulsing_r       <= pulsing_nxt;
      pulse_peak_r    <= pulse_peak_nxt;
      pulse_dur_r     <= pulse_dur_nxt;
      pulse_elapsed_r <= pulse_elapsed_nxt;
      pul_red_r       <= pul_red_nxt;
      pul_green_r     <= pul_green_nxt;
      pul_blue_r      <= pul_blue_nxt;
      since_render_r  <= since_render_nxt;
      since_update_r  <= since_update_nxt;
      unmuted_lit_r   <= unmuted_lit_nxt;
      resting_dirty_r <= resting_dirty_nxt;
      rest_red_r      <= rest_red_nxt;
      rest_green_r    <= rest_green_nxt;
      rest_blue_r     <= rest_blue_nxt;
      rest_bright_r   <= rest_bright_nxt;
      out_valid_r     <= out_valid_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    col_red_r   <= col_red_nxt;
    col_green_r <= col_green_nxt;
    col_blue_r  <= col_blue_nxt;
    bright_r    <= bright_nxt;
    remain_r    <= remain_nxt;
    prod_r      <= prod_nxt;
    den_r       <= den_nxt;
    num_r       <= num_nxt;
    dsh_r       <= dsh_nxt;
    quot_r      <= quot_nxt;
    div_cnt_r   <= div_cnt_nxt;
    out_red_r   <= out_red_nxt;
    out_green_r <= out_green_nxt;
    out_blue_r  <= out_blue_nxt;
  end

endmodule

@@ hw/rtl/led_pulse_envelope_driver_top.sv @@
// Top level of the LED pulse envelope driver.
//
// Usage:
//   in_req  : event requests (op = tick, voice trigger, beat, mute change).
//   out_rsp : one RGB drive request per tick that writes the LED; other
//             requests produce nothing.
//   APB     : seven configuration registers at byte address 4*index; write
//             them only while the block is idle. Reads return the register.
// Requests are classified on acceptance and queued (QUEUE_DEPTH entries);
// in_req.ready is low only while that queue is full.
// A tick that writes a fixed colour (pulse start, pulse end, resting) goes
// from the queue through the drive state to out_rsp; an envelope re-render
// first passes through two multiply stages and a restoring divider.
// Non-tick requests are handled in the idle state and produce nothing. The
// back end takes no new request until it has returned to the idle state.
// Reset (rst_n low, synchronous) clears the mailbox, pulse, timers, queue and
// configuration; no clearing pass is needed.
// A stalled out_rsp holds its request; the back end waits on it once it has
// a new colour to drive, while the queue keeps taking new requests until it fills.
module led_pulse_envelope_driver_top #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic         clk,
  input  logic         rst_n,
  lped_in_if.sink      in_req,
  lped_out_if.source   out_rsp,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [4:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  lped_pkg::cfg_t cfg_r, cfg_nxt;
  lped_pkg::cmd_t q_wr_data;
  lped_pkg::cmd_t q_rd_data;
  lped_pkg::reg_idx_t cfg_idx;
  logic q_push, q_pop, q_full, q_valid;
  logic cfg_wr;

  assign pready  = 1'b1;
  assign cfg_idx = lped_pkg::reg_idx_t'(paddr[4:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  // Configuration register writes
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr) begin
      unique case (cfg_idx)
        lped_pkg::REG_LED_MODE:     cfg_nxt.led_mode        = lped_pkg::mode_t'(pwdata[1:0]);
        lped_pkg::REG_SOURCE_VOICE: cfg_nxt.source_voice    = pwdata[3:0];
        lped_pkg::REG_COLOR_RED:    cfg_nxt.color_red       = pwdata[7:0];
        lped_pkg::REG_COLOR_GREEN:  cfg_nxt.color_green     = pwdata[7:0];
        lped_pkg::REG_COLOR_BLUE:   cfg_nxt.color_blue      = pwdata[7:0];
        lped_pkg::REG_BRIGHTNESS:   cfg_nxt.base_brightness = pwdata[7:0];
        lped_pkg::REG_FLASH_MS:     cfg_nxt.flash_ms        = pwdata[15:0];
        default: begin
        end
      endcase
    end
  end

  // Configuration read-back
  always_comb begin
    prdata = '0;
    unique case (cfg_idx)
      lped_pkg::REG_LED_MODE:     prdata = {30'd0, cfg_r.led_mode};
      lped_pkg::REG_SOURCE_VOICE: prdata = {28'd0, cfg_r.source_voice};
      lped_pkg::REG_COLOR_RED:    prdata = {24'd0, cfg_r.color_red};
      lped_pkg::REG_COLOR_GREEN:  prdata = {24'd0, cfg_r.color_green};
      lped_pkg::REG_COLOR_BLUE:   prdata = {24'd0, cfg_r.color_blue};
      lped_pkg::REG_BRIGHTNESS:   prdata = {24'd0, cfg_r.base_brightness};
      lped_pkg::REG_FLASH_MS:     prdata = {16'd0, cfg_r.flash_ms};
      default:                    prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  lped_front u_front (
    .cfg       (cfg_r),
    .req_valid (in_req.valid),
    .req_op    (in_req.op),
    .req_voice (in_req.voice),
    .req_muted (in_req.muted),
    .q_full    (q_full),
    .req_ready (in_req.ready),
    .q_push    (q_push),
    .q_data    (q_wr_data)
  );

  lped_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .wr_data (q_wr_data),
    .pop     (q_pop),
    .full    (q_full),
    .valid   (q_valid),
    .rd_data (q_rd_data)
  );

  lped_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_data    (q_rd_data),
    .q_pop     (q_pop),
    .out_valid (out_rsp.valid),
    .out_ready (out_rsp.ready),
    .out_red   (out_rsp.red),
    .out_green (out_rsp.green),
    .out_blue  (out_rsp.blue)
  );

  // Back end never pops an empty queue
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("queue popped while empty");

  // Front end never pushes into a full queue
  a_push_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full)
    else $error("queue pushed while full");

  // Voice triggers outside step-trigger mode are dropped at the front
  a_voice_dropped: assert property (@(posedge clk) disable iff (!rst_n)
    (in_req.valid && in_req.ready && in_req.op == lped_pkg::OP_VOICE &&
     cfg_r.led_mode != lped_pkg::MODE_STEP) |-> !q_push)
    else $error("ignored voice trigger entered the queue");

  // No result request right after reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_rsp.valid)
    else $error("result request valid after reset");

endmodule
